### rtl/core/pai_pkg.sv
// ----------------------------------------------------------------------------
// pai_pkg
// Types, breakpoint tables and codes for the particulate matter AQI block.
// ----------------------------------------------------------------------------
`default_nettype none

package pai_pkg;

	localparam int unsigned CONC_W = 16;
	localparam int unsigned AQI_W = 9;
	localparam int unsigned LVL_W = 3;
	localparam int unsigned DOM_W = 2;
	localparam int unsigned SEG_N = 6;
	localparam int unsigned SEG_W = $clog2(SEG_N);
	// widest segment span (fine, top segment) is 2495
	localparam int unsigned DIFF_W = 12;
	// slope fraction bits: 2^FRAC_W exceeds 2 * span * span for every segment
	localparam int unsigned FRAC_W = 24;
	localparam int unsigned MUL_W = FRAC_W + 1;
	localparam int unsigned PROD_W = DIFF_W + MUL_W;
	// largest rise within a segment is 199
	localparam int unsigned RISE_W = 8;

	localparam logic [AQI_W-1:0] AQI_MAX = AQI_W'(500);

	localparam logic [AQI_W-1:0] LIM_GOOD = AQI_W'(50);
	localparam logic [AQI_W-1:0] LIM_MODERATE = AQI_W'(100);
	localparam logic [AQI_W-1:0] LIM_SENSITIVE = AQI_W'(150);
	localparam logic [AQI_W-1:0] LIM_UNHEALTHY = AQI_W'(200);
	localparam logic [AQI_W-1:0] LIM_VERY_UNHEALTHY = AQI_W'(300);

	localparam logic [LVL_W-1:0] LVL_GOOD = 3'd0;
	localparam logic [LVL_W-1:0] LVL_MODERATE = 3'd1;
	localparam logic [LVL_W-1:0] LVL_SENSITIVE = 3'd2;
	localparam logic [LVL_W-1:0] LVL_UNHEALTHY = 3'd3;
	localparam logic [LVL_W-1:0] LVL_VERY_UNHEALTHY = 3'd4;
	localparam logic [LVL_W-1:0] LVL_HAZARDOUS = 3'd5;

	localparam logic [DOM_W-1:0] DOM_NONE = 2'd0;
	localparam logic [DOM_W-1:0] DOM_FINE = 2'd1;
	localparam logic [DOM_W-1:0] DOM_COARSE = 2'd2;

	typedef struct packed {
		logic              pm25_valid;
		logic [CONC_W-1:0] pm25_tenths;
		logic              pm10_valid;
		logic [CONC_W-1:0] pm10_whole;
	} in_t;

	typedef struct packed {
		logic             aqi_valid;
		logic [AQI_W-1:0] aqi_overall;
		logic [LVL_W-1:0] aqi_level;
		logic [DOM_W-1:0] dominant;
		logic             fine_sub_valid;
		logic [AQI_W-1:0] fine_subindex;
		logic             coarse_sub_valid;
		logic [AQI_W-1:0] coarse_subindex;
	} out_t;

	// slope is ceil(rise * 2^FRAC_W / span)
	typedef struct packed {
		logic [CONC_W-1:0] c_lo;
		logic [CONC_W-1:0] c_hi;
		logic [AQI_W-1:0]  i_lo;
		logic [MUL_W-1:0]  slope;
	} seg_t;

	typedef seg_t [0:SEG_N-1] seg_tab_t;

	// pm2.5 in tenths of ug/m3
	localparam seg_tab_t FINE_TAB = '{
		0: '{c_lo: 16'd0, c_hi: 16'd120, i_lo: 9'd0,
			slope: MUL_W'(((64'd50 << FRAC_W) + 64'd119) / 64'd120)},
		1: '{c_lo: 16'd121, c_hi: 16'd354, i_lo: 9'd51,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd232) / 64'd233)},
		2: '{c_lo: 16'd355, c_hi: 16'd554, i_lo: 9'd101,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd198) / 64'd199)},
		3: '{c_lo: 16'd555, c_hi: 16'd1504, i_lo: 9'd151,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd948) / 64'd949)},
		4: '{c_lo: 16'd1505, c_hi: 16'd2504, i_lo: 9'd201,
			slope: MUL_W'(((64'd99 << FRAC_W) + 64'd998) / 64'd999)},
		5: '{c_lo: 16'd2505, c_hi: 16'd5000, i_lo: 9'd301,
			slope: MUL_W'(((64'd199 << FRAC_W) + 64'd2494) / 64'd2495)}
	};

	// pm10 in whole ug/m3
	localparam seg_tab_t COARSE_TAB = '{
		0: '{c_lo: 16'd0, c_hi: 16'd54, i_lo: 9'd0,
			slope: MUL_W'(((64'd50 << FRAC_W) + 64'd53) / 64'd54)},
		1: '{c_lo: 16'd55, c_hi: 16'd154, i_lo: 9'd51,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd98) / 64'd99)},
		2: '{c_lo: 16'd155, c_hi: 16'd254, i_lo: 9'd101,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd98) / 64'd99)},
		3: '{c_lo: 16'd255, c_hi: 16'd354, i_lo: 9'd151,
			slope: MUL_W'(((64'd49 << FRAC_W) + 64'd98) / 64'd99)},
		4: '{c_lo: 16'd355, c_hi: 16'd424, i_lo: 9'd201,
			slope: MUL_W'(((64'd99 << FRAC_W) + 64'd68) / 64'd69)},
		5: '{c_lo: 16'd425, c_hi: 16'd604, i_lo: 9'd301,
			slope: MUL_W'(((64'd199 << FRAC_W) + 64'd178) / 64'd179)}
	};

endpackage

`default_nettype wire

### rtl/core/pai_subindex.sv
// ----------------------------------------------------------------------------
// pai_subindex
// Breakpoint segment lookup and linear interpolation for one pollutant.
// ----------------------------------------------------------------------------
`default_nettype none

module pai_subindex (
	input  wire logic                         valid,
	input  wire logic [pai_pkg::CONC_W-1:0]   conc,
	input  wire pai_pkg::seg_tab_t            tab,
	output logic [pai_pkg::AQI_W-1:0]         subindex
);

	localparam logic [pai_pkg::PROD_W-1:0] ROUND_HALF =
		pai_pkg::PROD_W'(1) << (pai_pkg::FRAC_W - 1);

	logic [pai_pkg::SEG_W-1:0]  sel;
	logic                       above;
	logic [pai_pkg::DIFF_W-1:0] diff;
	logic [pai_pkg::PROD_W-1:0] prod;
	logic [pai_pkg::RISE_W-1:0] step;

	always_comb begin
		sel = '0;
		for (int k = pai_pkg::SEG_N - 1; k >= 0; k--) begin
			if (conc <= tab[k].c_hi) begin
				sel = pai_pkg::SEG_W'(k);
			end
		end
	end

	assign above = conc > tab[pai_pkg::SEG_N-1].c_hi;
	assign diff = pai_pkg::DIFF_W'(conc - tab[sel].c_lo);
	assign prod = pai_pkg::PROD_W'(diff) * pai_pkg::PROD_W'(tab[sel].slope) + ROUND_HALF;
	assign step = prod[pai_pkg::FRAC_W +: pai_pkg::RISE_W];

	always_comb begin
		if (!valid) begin
			subindex = '0;
		end else if (above) begin
			subindex = pai_pkg::AQI_MAX;
		end else begin
			subindex = tab[sel].i_lo + pai_pkg::AQI_W'(step);
		end
	end

endmodule

`default_nettype wire

### rtl/core/pm_aqi_index.sv
// ----------------------------------------------------------------------------
// pm_aqi_index
// Air quality index from one pm2.5 and one pm10 reading per request.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  in      | in_valid, in_ready, in_data      | pai_pkg::in_t
//  out     | out_valid, out_ready, out_data   | pai_pkg::out_t
//
//  one request per cycle while the input stage is empty or the result can move;
//  each accepted request goes to the input register _s1, then its result to the
//  result register _q; the segment lookup and slope multiply sit between the
//  two register stages
//  arst_n clears both valid flags; payload registers are not reset
//  a stalled result holds in the result register while the input register
//  still takes a request whenever the result moves or the stage is empty
// ----------------------------------------------------------------------------
`default_nettype none

module pm_aqi_index (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pai_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pai_pkg::out_t      out_data
);

	logic                      vld_s1;
	pai_pkg::in_t              req_s1;
	logic                      out_vld_q;
	pai_pkg::out_t             res_q;
	logic                      adv;
	logic [pai_pkg::AQI_W-1:0] fine_sub;
	logic [pai_pkg::AQI_W-1:0] coarse_sub;
	pai_pkg::out_t             res;

	assign adv = !out_vld_q || out_ready;
	assign in_ready = !vld_s1 || adv;

	pai_subindex u_fine (
		.valid    (req_s1.pm25_valid),
		.conc     (req_s1.pm25_tenths),
		.tab      (pai_pkg::FINE_TAB),
		.subindex (fine_sub)
	);

	pai_subindex u_coarse (
		.valid    (req_s1.pm10_valid),
		.conc     (req_s1.pm10_whole),
		.tab      (pai_pkg::COARSE_TAB),
		.subindex (coarse_sub)
	);

	always_comb begin
		res = '0;
		res.fine_sub_valid = req_s1.pm25_valid;
		res.fine_subindex = fine_sub;
		res.coarse_sub_valid = req_s1.pm10_valid;
		res.coarse_subindex = coarse_sub;
		res.aqi_valid = req_s1.pm25_valid || req_s1.pm10_valid;
		if (req_s1.pm25_valid && (!req_s1.pm10_valid || fine_sub >= coarse_sub)) begin
			res.aqi_overall = fine_sub;
			res.dominant = pai_pkg::DOM_FINE;
		end else if (req_s1.pm10_valid) begin
			res.aqi_overall = coarse_sub;
			res.dominant = pai_pkg::DOM_COARSE;
		end else begin
			res.aqi_overall = '0;
			res.dominant = pai_pkg::DOM_NONE;
		end
		if (!res.aqi_valid) begin
			res.aqi_level = pai_pkg::LVL_GOOD;
		end else if (res.aqi_overall <= pai_pkg::LIM_GOOD) begin
			res.aqi_level = pai_pkg::LVL_GOOD;
		end else if (res.aqi_overall <= pai_pkg::LIM_MODERATE) begin
			res.aqi_level = pai_pkg::LVL_MODERATE;
		end else if (res.aqi_overall <= pai_pkg::LIM_SENSITIVE) begin
			res.aqi_level = pai_pkg::LVL_SENSITIVE;
		end else if (res.aqi_overall <= pai_pkg::LIM_UNHEALTHY) begin
			res.aqi_level = pai_pkg::LVL_UNHEALTHY;
		end else if (res.aqi_overall <= pai_pkg::LIM_VERY_UNHEALTHY) begin
			res.aqi_level = pai_pkg::LVL_VERY_UNHEALTHY;
		end else begin
			res.aqi_level = pai_pkg::LVL_HAZARDOUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv) begin
				out_vld_q <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (adv && vld_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data = res_q;

endmodule

`default_nettype wire

### dv/pm_aqi_index_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_aqi_index_tb
// Self-checking bench for the particulate matter AQI block. A directed set of
// breakpoint, tie and out-of-range readings is followed by random readings,
// with random gaps on both channels. A local breakpoint interpolation predicts
// each result, and every field is compared with the result that arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module pm_aqi_index_tb;

	localparam int unsigned N_RANDOM = 1550;

	// breakpoints: pm2.5 in tenths, pm10 in whole ug/m3
	localparam logic [0:5][15:0] FINE_LO =
		{16'd0, 16'd121, 16'd355, 16'd555, 16'd1505, 16'd2505};
	localparam logic [0:5][15:0] FINE_HI =
		{16'd120, 16'd354, 16'd554, 16'd1504, 16'd2504, 16'd5000};
	localparam logic [0:5][15:0] COARSE_LO =
		{16'd0, 16'd55, 16'd155, 16'd255, 16'd355, 16'd425};
	localparam logic [0:5][15:0] COARSE_HI =
		{16'd54, 16'd154, 16'd254, 16'd354, 16'd424, 16'd604};
	localparam logic [0:5][8:0] IDX_LO = {9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};
	localparam logic [0:5][8:0] IDX_HI = {9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd500};

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_ready;
	pai_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	pai_pkg::out_t out_data;

	pai_pkg::in_t  reading_q[$];
	pai_pkg::out_t aqi_due[$];
	int unsigned   errors = 0;
	int unsigned   cyc = 0;
	logic          in_taken = 1'b0;

	pm_aqi_index u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("pm_aqi_index regression: fail");
		$finish;
	end

	function automatic logic [pai_pkg::AQI_W-1:0] sub_aqi(
		input logic [pai_pkg::CONC_W-1:0] c, input bit fine);
		int unsigned lo, hi, span;
		for (int k = 0; k < pai_pkg::SEG_N; k++) begin
			lo = fine ? FINE_LO[k] : COARSE_LO[k];
			hi = fine ? FINE_HI[k] : COARSE_HI[k];
			if (c >= lo && c <= hi) begin
				span = hi - lo;
				return pai_pkg::AQI_W'((2 * (IDX_HI[k] - IDX_LO[k]) * (c - lo) + span)
					/ (2 * span) + IDX_LO[k]);
			end
		end
		return pai_pkg::AQI_MAX;
	endfunction

	function automatic logic [pai_pkg::LVL_W-1:0] level_of(
		input logic [pai_pkg::AQI_W-1:0] v);
		if (v <= pai_pkg::LIM_GOOD) return pai_pkg::LVL_GOOD;
		if (v <= pai_pkg::LIM_MODERATE) return pai_pkg::LVL_MODERATE;
		if (v <= pai_pkg::LIM_SENSITIVE) return pai_pkg::LVL_SENSITIVE;
		if (v <= pai_pkg::LIM_UNHEALTHY) return pai_pkg::LVL_UNHEALTHY;
		if (v <= pai_pkg::LIM_VERY_UNHEALTHY) return pai_pkg::LVL_VERY_UNHEALTHY;
		return pai_pkg::LVL_HAZARDOUS;
	endfunction

	function automatic pai_pkg::out_t aqi_of(input pai_pkg::in_t d);
		pai_pkg::out_t r;
		r = '0;
		r.fine_sub_valid = d.pm25_valid;
		r.coarse_sub_valid = d.pm10_valid;
		if (d.pm25_valid) r.fine_subindex = sub_aqi(d.pm25_tenths, 1'b1);
		if (d.pm10_valid) r.coarse_subindex = sub_aqi(d.pm10_whole, 1'b0);
		r.aqi_valid = d.pm25_valid | d.pm10_valid;
		if (d.pm25_valid && (!d.pm10_valid || r.fine_subindex >= r.coarse_subindex)) begin
			r.aqi_overall = r.fine_subindex;
			r.dominant = pai_pkg::DOM_FINE;
		end else if (d.pm10_valid) begin
			r.aqi_overall = r.coarse_subindex;
			r.dominant = pai_pkg::DOM_COARSE;
		end else begin
			r.dominant = pai_pkg::DOM_NONE;
		end
		r.aqi_level = r.aqi_valid ? level_of(r.aqi_overall) : pai_pkg::LVL_GOOD;
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic add_reading(input bit fv, input int unsigned fc, input bit cv,
		input int unsigned cc);
		pai_pkg::in_t d;
		d.pm25_valid = fv;
		d.pm25_tenths = pai_pkg::CONC_W'(fc);
		d.pm10_valid = cv;
		d.pm10_whole = pai_pkg::CONC_W'(cc);
		reading_q.push_back(d);
	endtask

	function automatic logic [pai_pkg::CONC_W-1:0] rand_conc(input bit fine);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 60) return pai_pkg::CONC_W'($urandom_range(fine ? 5100 : 650));
		if (pick < 80) return pai_pkg::CONC_W'($urandom_range(fine ? 600 : 260));
		if (pick < 90) begin
			return pai_pkg::CONC_W'(fine ? $urandom_range(5100, 4900)
				: $urandom_range(630, 580));
		end
		return pai_pkg::CONC_W'($urandom);
	endfunction

	// driver
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && (!in_valid || in_taken)) begin
			if (reading_q.size() != 0 && !((cyc < 600 || cyc >= 1100) && $urandom_range(99) < 21)) begin
				in_data <= reading_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (arst_n) out_ready <= (cyc >= 600 && cyc < 1100) || $urandom_range(99) >= 21;
	end

	// monitor
	always @(posedge clk) begin
		pai_pkg::out_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) aqi_due.push_back(aqi_of(in_data));
		if (arst_n && out_valid && out_ready) begin
			if (aqi_due.size() == 0) begin
				report("result with nothing expected");
			end else begin
				want = aqi_due.pop_front();
				check_field("aqi_valid", out_data.aqi_valid, want.aqi_valid);
				check_field("aqi_overall", out_data.aqi_overall, want.aqi_overall);
				check_field("aqi_level", out_data.aqi_level, want.aqi_level);
				check_field("dominant", out_data.dominant, want.dominant);
				check_field("fine_sub_valid", out_data.fine_sub_valid, want.fine_sub_valid);
				check_field("fine_subindex", out_data.fine_subindex, want.fine_subindex);
				check_field("coarse_sub_valid", out_data.coarse_sub_valid, want.coarse_sub_valid);
				check_field("coarse_subindex", out_data.coarse_subindex, want.coarse_subindex);
			end
		end
	end

	initial begin
		int unsigned pick;
		bit fv, cv;

		// no reading, single readings, zero and ties
		add_reading(0, 0, 0, 0);
		add_reading(0, 65535, 0, 65535);
		add_reading(1, 0, 0, 0);
		add_reading(0, 0, 1, 0);
		add_reading(1, 0, 1, 0);
		add_reading(1, 120, 1, 54);
		// segment edges on both tables
		add_reading(1, 121, 1, 55);
		add_reading(1, 354, 1, 154);
		add_reading(1, 355, 1, 155);
		add_reading(1, 554, 1, 254);
		add_reading(1, 555, 1, 255);
		add_reading(1, 1504, 1, 354);
		add_reading(1, 1505, 1, 355);
		add_reading(1, 2504, 1, 424);
		add_reading(1, 2505, 1, 425);
		add_reading(1, 5000, 1, 604);
		// above the top segment, plus one pm10 reading just inside its top segment
		add_reading(1, 5001, 1, 605);
		add_reading(1, 65535, 1, 65535);
		add_reading(1, 10, 1, 600);
		add_reading(1, 65535, 0, 0);
		add_reading(0, 0, 1, 65535);
		add_reading(1, 5001, 0, 65535);
		add_reading(0, 16'haaaa, 1, 16'h5555);
		add_reading(1, 16'h5555, 0, 16'haaaa);

		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(99);
			fv = pick < 82 || (pick >= 94 && pick < 97);
			cv = pick < 70 || (pick >= 82 && pick < 94);
			add_reading(fv, rand_conc(1'b1), cv, rand_conc(1'b0));
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (reading_q.size() != 0 || in_valid) @(posedge clk);
		while (aqi_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0) begin
			$display("pm_aqi_index regression: pass");
		end else begin
			$display("pm_aqi_index regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire
